// ===== design/evr_pkg.sv =====
// Shared constants, register indexes and series reciprocals for the Euler vector rotator.
// No dependencies.
package evr_pkg;

  localparam int ANGLE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TRIG_FRAC = 30;
  localparam int NUM_TERMS = 8;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [14:0] QUARTER = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd2;

  // ceil(2^s / ((2k)(2k+1))) for the sine series term k; exact for dividends below 2^32
  function automatic logic [32:0] series_recip(input logic [3:0] k);
    logic [32:0] m;
    case (k)
      4'd1:    m = 33'd5726623062;
      4'd2:    m = 33'd6871947674;
      4'd3:    m = 33'd6544712071;
      4'd4:    m = 33'd7635497416;
      4'd5:    m = 33'd4997780127;
      4'd6:    m = 33'd7048151461;
      4'd7:    m = 33'd5235769657;
      4'd8:    m = 33'd8084644322;
      default: m = 33'd5726623062;
    endcase
    return m;
  endfunction

  // shift s that goes with series_recip(k)
  function automatic logic [5:0] series_shift(input logic [3:0] k);
    logic [5:0] s;
    case (k)
      4'd1:    s = 6'd35;
      4'd2:    s = 6'd37;
      4'd3:    s = 6'd38;
      4'd4:    s = 6'd39;
      4'd5:    s = 6'd39;
      4'd6:    s = 6'd40;
      4'd7:    s = 6'd40;
      4'd8:    s = 6'd41;
      default: s = 6'd35;
    endcase
    return s;
  endfunction

endpackage

// ===== design/euler_vector_rotator_core.sv =====
// Euler-angle 3x3 vector rotator: matrix builder sequencer and vector pipeline.
// Depends on evr_pkg.
//
// One vector per cycle while not stalled by a rebuild or by m_axis_tready; a
// result passes the products, row sums, rounding and saturation stages. After
// reset and after every write of an angle register the coefficient matrix is
// rebuilt by a sequencer that shares one multiplier for the sine series, its
// reciprocal divisions and the matrix products, while s_axis_tready stays low.
// Angle register writes are taken at any time; each one restarts the rebuild.
module euler_vector_rotator_core #(
  parameter int COEF_FRAC_BITS = 15,
  parameter int VEC_WIDTH      = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [evr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [evr_pkg::ANGLE_W-1:0]           cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // vec_x, vec_y, vec_z
  input  logic [((3*VEC_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // rot_x, rot_y, rot_z
  output logic [((3*(VEC_WIDTH+1)+7)/8)*8-1:0]  m_axis_tdata
);

  localparam int F      = COEF_FRAC_BITS;
  localparam int VW     = VEC_WIDTH;
  localparam int CW     = F + 2;
  localparam int PW     = CW + VW;
  localparam int SW     = PW + 2;
  localparam int OW     = VW + 1;
  localparam int OUT_TW = ((3*OW+7)/8)*8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_XM   = 4'd1;
  localparam logic [3:0] ST_XS   = 4'd2;
  localparam logic [3:0] ST_X2M  = 4'd3;
  localparam logic [3:0] ST_X2S  = 4'd4;
  localparam logic [3:0] ST_TM   = 4'd5;
  localparam logic [3:0] ST_TS   = 4'd6;
  localparam logic [3:0] ST_DM   = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;
  localparam logic [3:0] ST_TRIG = 4'd9;
  localparam logic [3:0] ST_MM   = 4'd10;
  localparam logic [3:0] ST_MS   = 4'd11;

  localparam logic [2:0] MD_CEST = 3'd0;
  localparam logic [2:0] MD_SEST = 3'd1;
  localparam logic [2:0] MD_LOAD = 3'd2;
  localparam logic [2:0] MD_P    = 3'd3;
  localparam logic [2:0] MD_ADD  = 3'd4;
  localparam logic [2:0] MD_SUB  = 3'd5;
  localparam logic [2:0] MD_NEG  = 3'd6;

  localparam logic [2:0] T_SP = 3'd0;
  localparam logic [2:0] T_CP = 3'd1;
  localparam logic [2:0] T_ST = 3'd2;
  localparam logic [2:0] T_CT = 3'd3;
  localparam logic [2:0] T_SE = 3'd4;
  localparam logic [2:0] T_CE = 3'd5;
  localparam logic [2:0] T_A6 = 3'd6;  // cest for a, one for b
  localparam logic [2:0] T_A7 = 3'd7;  // sest for a

  localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< evr_pkg::TRIG_FRAC;

  // ---------------- matrix builder ----------------
  logic [3:0]                  state_q, state_d;
  logic [2:0]                  idx_q;
  logic [3:0]                  k_q;
  logic [3:0]                  step_q;
  logic [evr_pkg::ANGLE_W-1:0] ang_q [3];
  logic signed [31:0]          trig_q [6];
  logic signed [33:0]          cest_q, sest_q, acc_q;
  logic [31:0]                 x_q, x2_q;
  logic [32:0]                 term_q;
  logic [31:0]                 dvd_q;
  logic signed [34:0]          sum_q;
  logic signed [67:0]          prod_q;
  logic signed [33:0]          mul_a, mul_b;
  logic signed [CW-1:0]        coef_q [9];

  logic                        cfg_hit;
  logic [evr_pkg::ANGLE_W-1:0] ang_sel, ang_arg;
  logic [14:0]                 rr;
  logic                        neg;
  logic [32:0]                 quo;
  logic [2:0]                  sel_a, sel_b, mode;
  logic [3:0]                  dest;
  logic signed [33:0]          opa [8];
  logic signed [33:0]          opb [8];
  logic signed [67:0]          prod_rnd;
  logic signed [33:0]          p_rnd, cval, cval_r, csh;
  logic signed [CW-1:0]        cnew;
  logic signed [31:0]          trig_new;
  logic signed [34:0]          sum_clamp;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == evr_pkg::REG_ROLL ||
                                cfg_idx_i == evr_pkg::REG_PITCH ||
                                cfg_idx_i == evr_pkg::REG_YAW);

  assign ang_sel = ang_q[idx_q[2:1]];
  assign ang_arg = idx_q[0] ? ang_sel + evr_pkg::ANGLE_W'(evr_pkg::QUARTER) : ang_sel;
  assign rr      = ang_arg[14] ? evr_pkg::QUARTER - {1'b0, ang_arg[13:0]}
                               : {1'b0, ang_arg[13:0]};
  assign neg     = ang_arg[15];

  assign quo = 33'(prod_q >> evr_pkg::series_shift(k_q));

  always_comb begin
    sel_a = T_CE; sel_b = T_ST; mode = MD_CEST; dest = 4'd0;
    case (step_q)
      4'd0:    begin sel_a = T_CE; sel_b = T_ST; mode = MD_CEST; end
      4'd1:    begin sel_a = T_SE; sel_b = T_ST; mode = MD_SEST; end
      4'd2:    begin sel_a = T_CE; sel_b = T_CT; mode = MD_P;    dest = 4'd0; end
      4'd3:    begin sel_a = T_SE; sel_b = T_CP; mode = MD_LOAD; end
      4'd4:    begin sel_a = T_A6; sel_b = T_SP; mode = MD_ADD;  dest = 4'd3; end
      4'd5:    begin sel_a = T_SE; sel_b = T_SP; mode = MD_LOAD; end
      4'd6:    begin sel_a = T_A6; sel_b = T_CP; mode = MD_SUB;  dest = 4'd6; end
      4'd7:    begin sel_a = T_SE; sel_b = T_CT; mode = MD_NEG;  dest = 4'd1; end
      4'd8:    begin sel_a = T_CE; sel_b = T_CP; mode = MD_LOAD; end
      4'd9:    begin sel_a = T_A7; sel_b = T_SP; mode = MD_SUB;  dest = 4'd4; end
      4'd10:   begin sel_a = T_CE; sel_b = T_SP; mode = MD_LOAD; end
      4'd11:   begin sel_a = T_A7; sel_b = T_CP; mode = MD_ADD;  dest = 4'd7; end
      4'd12:   begin sel_a = T_ST; sel_b = T_A6; mode = MD_P;    dest = 4'd2; end
      4'd13:   begin sel_a = T_CT; sel_b = T_SP; mode = MD_NEG;  dest = 4'd5; end
      4'd14:   begin sel_a = T_CT; sel_b = T_CP; mode = MD_P;    dest = 4'd8; end
      default: begin sel_a = T_CE; sel_b = T_ST; mode = MD_CEST; end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa[i] = 34'(trig_q[i]);
      opb[i] = 34'(trig_q[i]);
    end
    opa[6] = cest_q;
    opa[7] = sest_q;
    opb[6] = ONE_Q30;
    opb[7] = ONE_Q30;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_XM:   begin mul_a = $signed({19'd0, rr});  mul_b = $signed({2'b0, evr_pkg::PI_Q30}); end
      ST_X2M:  begin mul_a = $signed({2'b0, x_q});  mul_b = $signed({2'b0, x_q}); end
      ST_TM:   begin mul_a = $signed({1'b0, term_q}); mul_b = $signed({2'b0, x2_q}); end
      ST_DM:   begin
        mul_a = $signed({1'b0, evr_pkg::series_recip(k_q)});
        mul_b = $signed({2'b0, dvd_q});
      end
      ST_MM:   begin mul_a = opa[sel_a];            mul_b = opb[sel_b]; end
      default: begin mul_a = '0;                    mul_b = '0; end
    endcase
  end

  // matrix step arithmetic
  assign prod_rnd = prod_q + (68'sd1 <<< (evr_pkg::TRIG_FRAC - 1));
  assign p_rnd    = prod_rnd[63:30];

  always_comb begin
    case (mode)
      MD_ADD:  cval = acc_q + p_rnd;
      MD_SUB:  cval = acc_q - p_rnd;
      MD_NEG:  cval = -p_rnd;
      default: cval = p_rnd;
    endcase
    cval_r = cval + (34'sd1 <<< (evr_pkg::TRIG_FRAC - F - 1));
    csh    = cval_r >>> (evr_pkg::TRIG_FRAC - F);
    if (csh > (34'sd1 <<< F)) begin
      cnew = CW'(34'sd1 <<< F);
    end else if (csh < -(34'sd1 <<< F)) begin
      cnew = CW'(-(34'sd1 <<< F));
    end else begin
      cnew = CW'(csh);
    end
  end

  always_comb begin
    if (sum_q < 0) begin
      sum_clamp = '0;
    end else if (sum_q > (35'sd1 <<< evr_pkg::TRIG_FRAC)) begin
      sum_clamp = 35'sd1 <<< evr_pkg::TRIG_FRAC;
    end else begin
      sum_clamp = sum_q;
    end
    trig_new = neg ? -32'(sum_clamp) : 32'(sum_clamp);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_XM:   state_d = ST_XS;
      ST_XS:   state_d = ST_X2M;
      ST_X2M:  state_d = ST_X2S;
      ST_X2S:  state_d = ST_TM;
      ST_TM:   state_d = ST_TS;
      ST_TS:   state_d = ST_DM;
      ST_DM:   state_d = ST_ACC;
      ST_ACC:  state_d = (k_q == 4'(evr_pkg::NUM_TERMS)) ? ST_TRIG : ST_TM;
      ST_TRIG: state_d = (idx_q == T_CE) ? ST_MM : ST_XM;
      ST_MM:   state_d = ST_MS;
      ST_MS:   state_d = (step_q == 4'd14) ? ST_IDLE : ST_MM;
      default: state_d = ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_d = ST_XM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_XM;
      idx_q   <= '0;
      k_q     <= 4'd1;
      step_q  <= '0;
      ang_q   <= '{default: '0};
    end else begin
      state_q <= state_d;
      if (cfg_hit) begin
        ang_q[cfg_idx_i] <= cfg_wdata_i;
        idx_q  <= '0;
        step_q <= '0;
      end else begin
        case (state_q)
          ST_X2S:  k_q <= 4'd1;
          ST_ACC:  k_q <= k_q + 4'd1;
          ST_TRIG: idx_q <= idx_q + 3'd1;
          ST_MS:   step_q <= step_q + 4'd1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_XM || state_q == ST_X2M || state_q == ST_TM || state_q == ST_DM ||
        state_q == ST_MM) begin
      prod_q <= mul_a * mul_b;
    end
    case (state_q)
      ST_XS: begin
        x_q    <= 32'((prod_q + 68'sd16384) >>> 15);
        term_q <= 33'((prod_q + 68'sd16384) >>> 15);
        sum_q  <= 35'((prod_q + 68'sd16384) >>> 15);
      end
      ST_X2S: x2_q <= prod_q[61:30];
      ST_TS:  dvd_q <= prod_q[61:30];
      ST_ACC: begin
        term_q <= quo;
        if (k_q[0]) begin
          sum_q <= sum_q - $signed({2'b0, quo});
        end else begin
          sum_q <= sum_q + $signed({2'b0, quo});
        end
      end
      ST_TRIG: trig_q[idx_q] <= trig_new;
      ST_MS: begin
        case (mode)
          MD_CEST: cest_q <= p_rnd;
          MD_SEST: sest_q <= p_rnd;
          MD_LOAD: acc_q  <= p_rnd;
          default: coef_q[dest] <= cnew;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------- vector pipeline ----------------
  logic                 v1_q, v2_q, v3_q;
  logic                 rdy1, rdy2, rdy3, in_acc;
  logic signed [PW-1:0] prod1_q [9];
  logic signed [SW-1:0] sum2_q [3];
  logic signed [OW-1:0] rot_q [3];
  logic signed [VW-1:0] vec [3];
  logic signed [SW-1:0] shv [3];

  localparam logic signed [SW-1:0] OUT_HI = (SW'(1) <<< VW) - SW'(1);
  localparam logic signed [SW-1:0] OUT_LO = -(SW'(1) <<< VW);

  assign vec[0] = s_axis_tdata[VW-1:0];
  assign vec[1] = s_axis_tdata[2*VW-1:VW];
  assign vec[2] = s_axis_tdata[3*VW-1:2*VW];

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1 && (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_acc;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shv[r] = sum2_q[r] >>> F;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 9; i++) begin
        prod1_q[i] <= PW'(coef_q[i]) * PW'(vec[i % 3]);
      end
    end
    if (v1_q && rdy2) begin
      for (int r = 0; r < 3; r++) begin
        sum2_q[r] <= SW'(prod1_q[3*r]) + SW'(prod1_q[3*r+1]) + SW'(prod1_q[3*r+2])
                   + (SW'(1) <<< (F - 1));
      end
    end
    if (v2_q && rdy3) begin
      for (int r = 0; r < 3; r++) begin
        if (shv[r] > OUT_HI) begin
          rot_q[r] <= OW'(OUT_HI);
        end else if (shv[r] < OUT_LO) begin
          rot_q[r] <= OW'(OUT_LO);
        end else begin
          rot_q[r] <= OW'(shv[r]);
        end
      end
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = OUT_TW'({rot_q[2], rot_q[1], rot_q[0]});

endmodule

// ===== design/evr_checker.sv =====
// Port-level checks for the Euler vector rotator, bound to its top level.
// Depends on evr_pkg and euler_vector_rotator_core.
module evr_checker #(
  parameter int VEC_WIDTH = 16
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  cfg_we_i,
  input logic [evr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [((3*(VEC_WIDTH+1)+7)/8)*8-1:0]  m_axis_tdata
);

  // an angle write stalls the input while the matrix is rebuilt
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == evr_pkg::REG_ROLL || cfg_idx_i == evr_pkg::REG_PITCH ||
                 cfg_idx_i == evr_pkg::REG_YAW) |=> !s_axis_tready)
    else $error("input ready during matrix rebuild");

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid in reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

endmodule

bind euler_vector_rotator_core evr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_evr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
